[hw/rtl/sra_pkg.sv]
// Shared types, constants and status codes of the segment reassembly table.
package sra_pkg;

   localparam int TABLE_ENTRIES_DEF = 8;
   localparam int MAX_SEGS_DEF      = 16;
   localparam int QUEUE_DEPTH       = 2;
   localparam int ENTRY_FIELD_W     = 3;
   localparam int BYTES_W           = 12;

   localparam logic [2:0] ST_STORED  = 3'd0;
   localparam logic [2:0] ST_DUP     = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_RANGE   = 3'd3;
   localparam logic [2:0] ST_DESC    = 3'd4;
   localparam logic [2:0] ST_IGNORED = 3'd5;
   localparam logic [2:0] ST_UNSEG   = 3'd6;

   typedef struct packed {
      logic        is_deliver;
      logic        has_concat_header;
      logic [15:0] msg_ref;
      logic [7:0]  total_seg;
      logic [7:0]  seq_num;
      logic [7:0]  seg_length;
   } req_type;

   typedef struct packed {
      logic [2:0]               status;
      logic [ENTRY_FIELD_W-1:0] entry;
      logic [7:0]               out_seq;
      logic [7:0]               out_length;
      logic [BYTES_W-1:0]       total_length;
      logic                     last;
   } rsp_type;

   typedef struct packed {
      logic    complete;
      rsp_type result;
   } job_type;

endpackage

[hw/rtl/sra_stream_if.sv]
// Valid/ready channel interfaces for segment requests and reassembly results.
interface sra_req_if import sra_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface sra_rsp_if import sra_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/sra_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/sra_queue.sv]
// Short FIFO of jobs between the classifying front end and the output back end.
module sra_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("job pushed into full queue");

endmodule

[hw/rtl/sra_front.sv]
// Front end: registers a segment request, matches it against the table and classifies it.
module sra_front import sra_pkg::*; #(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int MAX_SEGS      = MAX_SEGS_DEF,
   localparam int ENTRY_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
   localparam int ADDR_W  = $clog2(TABLE_ENTRIES * MAX_SEGS)
) (
   input  logic                clock,
   input  logic                reset,
   sra_req_if.sink             req_bus,
   output logic                push,
   output job_type             push_job,
   output logic [ENTRY_W-1:0]  push_entry,
   output logic [MAX_SEGS-1:0] push_map,
   input  logic                queue_full,
   output logic                wr_en,
   output logic [ADDR_W-1:0]   wr_addr,
   output logic [7:0]          wr_data,
   input  logic                rel_valid,
   input  logic [ENTRY_W-1:0]  rel_entry
);

   localparam int SLOT_W  = $clog2(MAX_SEGS);
   localparam int COUNT_W = $clog2(MAX_SEGS + 1);

   req_type                  item_ff;
   logic                     item_valid_ff, item_valid_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [TABLE_ENTRIES-1:0] busy_ff, busy_in;
   logic [15:0]              ref_ff   [TABLE_ENTRIES];
   logic [COUNT_W-1:0]       count_ff [TABLE_ENTRIES];
   logic [BYTES_W-1:0]       bytes_ff [TABLE_ENTRIES];
   logic [MAX_SEGS-1:0]      map_ff   [TABLE_ENTRIES];

   logic                     in_range;
   logic [SLOT_W-1:0]        slot;
   logic [MAX_SEGS-1:0]      seg_bit;
   logic                     hit_found, free_found;
   logic [ENTRY_W-1:0]       hit_idx, free_idx, tgt_idx;
   logic [MAX_SEGS-1:0]      cur_map, new_map;
   logic [COUNT_W-1:0]       cur_count, new_count;
   logic [BYTES_W-1:0]       cur_bytes, new_bytes;
   logic                     dup, complete, store, stall, fire, accept;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !item_valid_ff && !reset;

   always_comb begin
      in_range = (item_ff.seq_num != 8'd0) && (item_ff.seq_num <= 8'(MAX_SEGS));
      slot     = SLOT_W'(item_ff.seq_num - 8'd1);
      seg_bit  = '0;
      seg_bit[slot] = 1'b1;

      hit_found  = 1'b0;
      hit_idx    = '0;
      free_found = 1'b0;
      free_idx   = '0;
      for (int e = 0; e < TABLE_ENTRIES; e++) begin
         if (valid_ff[e]) begin
            if (!hit_found && ref_ff[e] == item_ff.msg_ref) begin
               hit_found = 1'b1;
               hit_idx   = ENTRY_W'(e);
            end
         end else if (!free_found) begin
            free_found = 1'b1;
            free_idx   = ENTRY_W'(e);
         end
      end

      tgt_idx   = hit_found ? hit_idx : free_idx;
      cur_map   = hit_found ? map_ff[hit_idx] : '0;
      cur_count = hit_found ? count_ff[hit_idx] : '0;
      cur_bytes = hit_found ? bytes_ff[hit_idx] : '0;
      dup       = hit_found && ((cur_map & seg_bit) != '0);
      new_map   = cur_map | seg_bit;
      new_count = cur_count + COUNT_W'(1);
      new_bytes = cur_bytes + BYTES_W'(item_ff.seg_length);
      complete  = (8'(new_count) == item_ff.total_seg);
   end

   always_comb begin
      push_job                     = '0;
      push_job.result.last         = 1'b1;
      push_job.result.out_seq      = item_ff.seq_num;
      push_job.result.out_length   = item_ff.seg_length;
      store = 1'b0;
      stall = 1'b0;
      if (!item_ff.is_deliver) begin
         push_job.result.status     = ST_IGNORED;
         push_job.result.out_seq    = 8'd0;
         push_job.result.out_length = 8'd0;
      end else if (!item_ff.has_concat_header) begin
         push_job.result.status       = ST_UNSEG;
         push_job.result.out_seq      = 8'd1;
         push_job.result.total_length = BYTES_W'(item_ff.seg_length);
      end else if (!in_range) begin
         push_job.result.status = ST_RANGE;
      end else if (dup) begin
         push_job.result.status       = ST_DUP;
         push_job.result.entry        = ENTRY_FIELD_W'(hit_idx);
         push_job.result.total_length = cur_bytes;
      end else if (!hit_found && !free_found) begin
         push_job.result.status = ST_FULL;
      end else if (!hit_found && busy_ff[free_idx]) begin
         stall = 1'b1;
      end else begin
         store                        = 1'b1;
         push_job.complete            = complete;
         push_job.result.status       = complete ? ST_DESC : ST_STORED;
         push_job.result.entry        = ENTRY_FIELD_W'(tgt_idx);
         push_job.result.total_length = new_bytes;
      end
   end

   assign fire       = item_valid_ff && !queue_full && !stall;
   assign push       = fire;
   assign push_entry = tgt_idx;
   assign push_map   = new_map;
   assign wr_en      = fire && store;
   assign wr_addr    = ADDR_W'(int'(tgt_idx) * MAX_SEGS + int'(slot));
   assign wr_data    = item_ff.seg_length;

   always_comb begin
      item_valid_in = item_valid_ff;
      valid_in      = valid_ff;
      busy_in       = busy_ff;
      if (fire) begin
         item_valid_in = 1'b0;
      end
      if (accept) begin
         item_valid_in = 1'b1;
      end
      if (rel_valid) begin
         busy_in[rel_entry] = 1'b0;
      end
      if (fire && store) begin
         valid_in[tgt_idx] = !complete;
         busy_in[tgt_idx]  = complete;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         valid_ff      <= '0;
         busy_ff       <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         valid_ff      <= valid_in;
         busy_ff       <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_bus.data;
      end
      if (fire && store) begin
         ref_ff[tgt_idx]   <= item_ff.msg_ref;
         count_ff[tgt_idx] <= new_count;
         bytes_ff[tgt_idx] <= new_bytes;
         map_ff[tgt_idx]   <= complete ? '0 : new_map;
      end
   end

   a_busy_not_valid: assert property (@(posedge clock) disable iff (reset)
      (busy_ff & valid_ff) == '0)
      else $error("entry both open and draining");

   a_release_busy: assert property (@(posedge clock) disable iff (reset)
      rel_valid |-> busy_ff[rel_entry])
      else $error("release of an entry that is not draining");

endmodule

[hw/rtl/sra_back.sv]
// Back end: delivers queued results and walks completed entries into descriptors.
module sra_back import sra_pkg::*; #(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int MAX_SEGS      = MAX_SEGS_DEF,
   localparam int ENTRY_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
   localparam int ADDR_W  = $clog2(TABLE_ENTRIES * MAX_SEGS)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                empty,
   input  job_type             pop_job,
   input  logic [ENTRY_W-1:0]  pop_entry,
   input  logic [MAX_SEGS-1:0] pop_map,
   output logic                pop,
   output logic                rd_en,
   output logic [ADDR_W-1:0]   rd_addr,
   input  logic [7:0]          rd_data,
   output logic                rel_valid,
   output logic [ENTRY_W-1:0]  rel_entry,
   sra_rsp_if.source           rsp_bus
);

   localparam int SLOT_W = $clog2(MAX_SEGS);

   typedef enum logic [2:0] {
      BK_IDLE = 3'b001,
      BK_READ = 3'b010,
      BK_EMIT = 3'b100
   } back_state_type;

   back_state_type      state_ff, state_in;
   logic [MAX_SEGS-1:0] map_ff, map_in;
   logic [ENTRY_W-1:0]  entry_ff, entry_in;
   logic [BYTES_W-1:0]  total_ff, total_in;
   logic [7:0]          seq_ff, seq_in;
   logic                last_ff, last_in;
   rsp_type             out_ff, out_in;
   logic                out_valid_ff, out_valid_in;
   logic                out_free, load_out;
   logic [SLOT_W-1:0]   low_slot;
   logic [MAX_SEGS-1:0] low_bit;

   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.data  = out_ff;
   assign rel_entry     = entry_ff;

   always_comb begin
      low_slot = '0;
      for (int s = MAX_SEGS - 1; s >= 0; s--) begin
         if (map_ff[s]) begin
            low_slot = SLOT_W'(s);
         end
      end
      low_bit = '0;
      low_bit[low_slot] = 1'b1;
   end

   always_comb begin
      state_in  = state_ff;
      map_in    = map_ff;
      entry_in  = entry_ff;
      total_in  = total_ff;
      seq_in    = seq_ff;
      last_in   = last_ff;
      out_in    = out_ff;
      load_out  = 1'b0;
      pop       = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = ADDR_W'(int'(entry_ff) * MAX_SEGS + int'(low_slot));
      rel_valid = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!empty) begin
               if (!pop_job.complete) begin
                  if (out_free) begin
                     pop      = 1'b1;
                     load_out = 1'b1;
                     out_in   = pop_job.result;
                  end
               end else begin
                  pop      = 1'b1;
                  map_in   = pop_map;
                  entry_in = pop_entry;
                  total_in = pop_job.result.total_length;
                  state_in = BK_READ;
               end
            end
         end
         BK_READ: begin
            rd_en    = 1'b1;
            seq_in   = 8'(low_slot) + 8'd1;
            map_in   = map_ff & ~low_bit;
            last_in  = ((map_ff & ~low_bit) == '0);
            state_in = BK_EMIT;
         end
         BK_EMIT: begin
            if (out_free) begin
               load_out            = 1'b1;
               out_in.status       = ST_DESC;
               out_in.entry        = ENTRY_FIELD_W'(entry_ff);
               out_in.out_seq      = seq_ff;
               out_in.out_length   = rd_data;
               out_in.total_length = total_ff;
               out_in.last         = last_ff;
               if (last_ff) begin
                  rel_valid = 1'b1;
                  state_in  = BK_IDLE;
               end else begin
                  state_in = BK_READ;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      map_ff   <= map_in;
      entry_ff <= entry_in;
      total_ff <= total_in;
      seq_ff   <= seq_in;
      last_ff  <= last_in;
      out_ff   <= out_in;
   end

   a_read_has_segment: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_READ |-> map_ff != '0)
      else $error("descriptor read with no segment left");

   a_release_on_last: assert property (@(posedge clock) disable iff (reset)
      rel_valid |-> (state_ff == BK_EMIT && last_ff && load_out))
      else $error("entry released before its last descriptor");

endmodule

[hw/rtl/segment_reassembly_table.sv]
// Top level of the segment reassembly table.
// Each request is one received segment header and gives one result, except the
// segment that completes a message, which gives one descriptor per stored segment
// in ascending sequence order, the last marked. In the front end a request is
// first registered, then goes through the parallel reference match and table
// update. Descriptors of a completed message are paced by the read port of the
// segment length RAM (read, then register), one read per descriptor. A queue of
// QUEUE_DEPTH jobs lets requests keep flowing while descriptors drain; a new
// message that needs the table entry still being drained waits for it. No
// clearing pass follows reset.
module segment_reassembly_table import sra_pkg::*; #(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int MAX_SEGS      = MAX_SEGS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   sra_req_if.sink   req_bus,
   sra_rsp_if.source rsp_bus
);

   localparam int ENTRY_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int DEPTH   = TABLE_ENTRIES * MAX_SEGS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int Q_W     = $bits(job_type) + ENTRY_W + MAX_SEGS;

   logic                push, pop, queue_full, queue_empty;
   job_type             push_job, pop_job;
   logic [ENTRY_W-1:0]  push_entry, pop_entry, rel_entry;
   logic [MAX_SEGS-1:0] push_map, pop_map;
   logic [Q_W-1:0]      push_data, pop_data;
   logic                wr_en, rd_en, rel_valid;
   logic [ADDR_W-1:0]   wr_addr, rd_addr;
   logic [7:0]          wr_data, rd_data;

   assign push_data = {push_job, push_entry, push_map};
   assign {pop_job, pop_entry, pop_map} = pop_data;

   sra_front #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .MAX_SEGS      (MAX_SEGS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push       (push),
      .push_job   (push_job),
      .push_entry (push_entry),
      .push_map   (push_map),
      .queue_full (queue_full),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rel_valid  (rel_valid),
      .rel_entry  (rel_entry)
   );

   sra_queue #(
      .WIDTH (Q_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   sra_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sra_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .MAX_SEGS      (MAX_SEGS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (queue_empty),
      .pop_job   (pop_job),
      .pop_entry (pop_entry),
      .pop_map   (pop_map),
      .pop       (pop),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rel_valid (rel_valid),
      .rel_entry (rel_entry),
      .rsp_bus   (rsp_bus)
   );

endmodule

[verif/segment_reassembly_table_tb.sv]
// Self-checking testbench for the segment reassembly table.
`timescale 1ns / 100ps

module segment_reassembly_table_tb;
   import sra_pkg::*;

   localparam int NUM_ENTRIES = TABLE_ENTRIES_DEF;
   localparam int SEG_LIMIT   = MAX_SEGS_DEF;
   localparam int RANDOM_REQS = 170;

   logic clock;
   logic reset;

   sra_req_if req_bus ();
   sra_rsp_if rsp_bus ();

   segment_reassembly_table uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   req_type header_queue [$];
   rsp_type predicted_results [$];
   int      failures;
   int      accepted_reqs;

   logic        open_valid [NUM_ENTRIES];
   logic [15:0] open_ref   [NUM_ENTRIES];
   logic [4:0]  open_count [NUM_ENTRIES];
   logic [11:0] open_bytes [NUM_ENTRIES];
   logic [15:0] open_map   [NUM_ENTRIES];
   logic [7:0]  open_len   [NUM_ENTRIES][SEG_LIMIT];

   req_type msg_seg [2][2*SEG_LIMIT];
   int      msg_size [2];
   int      msg_pos [2];

   always #6 clock = ~clock;

   function automatic req_type make_header(logic dlv, logic cat, logic [15:0] id,
                                           logic [7:0] tot, logic [7:0] seq,
                                           logic [7:0] len);
      req_type h;
      h.is_deliver        = dlv;
      h.has_concat_header = cat;
      h.msg_ref           = id;
      h.total_seg         = tot;
      h.seq_num           = seq;
      h.seg_length        = len;
      return h;
   endfunction

   task automatic enqueue_header(req_type h);
      header_queue = {header_queue, h};
   endtask

   task automatic emit(logic [2:0] st, int ent, logic [7:0] seq, logic [7:0] len,
                       logic [11:0] tot, logic fin);
      rsp_type r;
      r.status       = st;
      r.entry        = 3'(ent);
      r.out_seq      = seq;
      r.out_length   = len;
      r.total_length = tot;
      r.last         = fin;
      predicted_results = {predicted_results, r};
   endtask

   task automatic reassemble_segment(req_type h);
      int hit;
      int free_e;
      int idx;
      int sent;
      hit    = -1;
      free_e = -1;
      idx    = int'(h.seq_num) - 1;
      if (!h.is_deliver) begin
         emit(ST_IGNORED, 0, 8'd0, 8'd0, 12'd0, 1'b1);
      end else if (!h.has_concat_header) begin
         emit(ST_UNSEG, 0, 8'd1, h.seg_length, {4'd0, h.seg_length}, 1'b1);
      end else if (h.seq_num == 8'd0 || int'(h.seq_num) > SEG_LIMIT) begin
         emit(ST_RANGE, 0, h.seq_num, h.seg_length, 12'd0, 1'b1);
      end else begin
         for (int e = 0; e < NUM_ENTRIES; e++) begin
            if (open_valid[e]) begin
               if (hit < 0 && open_ref[e] == h.msg_ref) hit = e;
            end else if (free_e < 0) begin
               free_e = e;
            end
         end
         if (hit >= 0 && open_map[hit][idx]) begin
            emit(ST_DUP, hit, h.seq_num, h.seg_length, open_bytes[hit], 1'b1);
         end else if (hit < 0 && free_e < 0) begin
            emit(ST_FULL, 0, h.seq_num, h.seg_length, 12'd0, 1'b1);
         end else begin
            if (hit < 0) begin
               hit             = free_e;
               open_valid[hit] = 1'b1;
               open_ref[hit]   = h.msg_ref;
               open_count[hit] = 5'd0;
               open_bytes[hit] = 12'd0;
               open_map[hit]   = 16'd0;
            end
            open_map[hit][idx] = 1'b1;
            open_len[hit][idx] = h.seg_length;
            open_count[hit]    = open_count[hit] + 5'd1;
            open_bytes[hit]    = open_bytes[hit] + {4'd0, h.seg_length};
            if ({3'd0, open_count[hit]} != h.total_seg) begin
               emit(ST_STORED, hit, h.seq_num, h.seg_length, open_bytes[hit], 1'b1);
            end else begin
               sent = 0;
               for (int s = 0; s < SEG_LIMIT; s++) begin
                  if (open_map[hit][s]) begin
                     sent++;
                     emit(ST_DESC, hit, 8'(s + 1), open_len[hit][s], open_bytes[hit],
                          sent == int'(open_count[hit]));
                  end
               end
               open_valid[hit] = 1'b0;
               open_map[hit]   = 16'd0;
            end
         end
      end
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         failures++;
      end
   endtask

   function automatic logic [7:0] bad_total();
      if ($urandom_range(0, 1) == 0) return 8'd0;
      return 8'($urandom_range(SEG_LIMIT + 1, 255));
   endfunction

   task automatic add_noise();
      case ($urandom_range(0, 2))
         0: enqueue_header(make_header(1'b0, 1'($urandom), 16'($urandom),
                                       8'($urandom), 8'($urandom), 8'($urandom)));
         1: enqueue_header(make_header(1'b1, 1'b0, 16'($urandom),
                                       8'($urandom), 8'($urandom), 8'($urandom)));
         default: enqueue_header(make_header(1'b1, 1'b1, 16'($urandom),
                                             8'($urandom),
                                             ($urandom_range(0, 3) == 0) ? 8'd0 :
                                             8'($urandom_range(SEG_LIMIT + 1, 255)),
                                             8'($urandom)));
      endcase
   endtask

   task automatic build_message(int m, logic [15:0] id, int n);
      int ord [SEG_LIMIT];
      int i;
      int j;
      int t;
      int k;
      logic [7:0] tot;
      for (i = 0; i < SEG_LIMIT; i++) ord[i] = i + 1;
      for (i = SEG_LIMIT - 1; i > 0; i--) begin
         j      = $urandom_range(0, i);
         t      = ord[i];
         ord[i] = ord[j];
         ord[j] = t;
      end
      k = 0;
      for (i = 0; i < n; i++) begin
         if (i == n - 1 || $urandom_range(0, 3) != 0) tot = 8'(n);
         else tot = bad_total();
         msg_seg[m][k] = make_header(1'b1, 1'b1, id, tot, 8'(ord[i]), 8'($urandom));
         k++;
         if (i < n - 1 && $urandom_range(0, 5) == 0) begin
            msg_seg[m][k] = make_header(1'b1, 1'b1, id, 8'($urandom), 8'(ord[i]),
                                        8'($urandom));
            k++;
         end
      end
      msg_size[m] = k;
      msg_pos[m]  = 0;
   endtask

   task automatic add_message_pair(bit force_big);
      logic [15:0] id_a;
      logic [15:0] id_b;
      int m;
      id_a = 16'($urandom);
      do id_b = 16'($urandom); while (id_b == id_a);
      build_message(0, id_a, force_big ? SEG_LIMIT :
                    ($urandom_range(0, 7) == 0) ? $urandom_range(5, SEG_LIMIT) :
                    $urandom_range(1, 4));
      build_message(1, id_b, ($urandom_range(0, 7) == 0) ? $urandom_range(5, SEG_LIMIT) :
                    $urandom_range(1, 4));
      while (msg_pos[0] < msg_size[0] || msg_pos[1] < msg_size[1]) begin
         if ($urandom_range(0, 7) == 0) begin
            add_noise();
         end else begin
            if (msg_pos[0] >= msg_size[0]) m = 1;
            else if (msg_pos[1] >= msg_size[1]) m = 0;
            else m = $urandom_range(0, 1);
            enqueue_header(msg_seg[m][msg_pos[m]]);
            msg_pos[m]++;
         end
      end
   endtask

   task automatic build_stimulus();
      int target;
      enqueue_header(make_header(1'b0, 1'b1, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
      enqueue_header(make_header(1'b1, 1'b0, 16'hFFFF, 8'hFF, 8'hFF, 8'd0));
      enqueue_header(make_header(1'b1, 1'b0, 16'h0000, 8'h00, 8'h00, 8'hFF));
      enqueue_header(make_header(1'b1, 1'b1, 16'h1234, 8'd2, 8'd0, 8'hFF));
      enqueue_header(make_header(1'b1, 1'b1, 16'h1234, 8'd2, 8'd17, 8'd1));
      enqueue_header(make_header(1'b1, 1'b1, 16'h1234, 8'd2, 8'hFF, 8'd0));
      for (int e = 0; e < NUM_ENTRIES - 1; e++) begin
         enqueue_header(make_header(1'b1, 1'b1,
                                    (e == 0) ? 16'h0000 : (e == 1) ? 16'hFFFF :
                                    16'(16'h1000 + e), 8'd2, 8'd1,
                                    (e == 2) ? 8'hFF : 8'(e * 36)));
      end
      enqueue_header(make_header(1'b1, 1'b1, 16'hABCD, 8'd0, 8'(SEG_LIMIT), 8'hFF));
      enqueue_header(make_header(1'b1, 1'b1, 16'h5555, 8'd1, 8'd1, 8'd77));
      enqueue_header(make_header(1'b1, 1'b1, 16'hFFFF, 8'd2, 8'd1, 8'd9));
      for (int e = 0; e < NUM_ENTRIES - 1; e++) begin
         enqueue_header(make_header(1'b1, 1'b1,
                                    (e == 0) ? 16'h0000 : (e == 1) ? 16'hFFFF :
                                    16'(16'h1000 + e), 8'd2, 8'd2,
                                    8'(255 - e * 20)));
      end
      enqueue_header(make_header(1'b1, 1'b1, 16'hABCD, 8'd2, 8'd1, 8'd0));
      target = RANDOM_REQS;
      add_message_pair(1'b1);
      while (header_queue.size() < target) add_message_pair(1'b0);
   endtask

   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left    <= 1;
         gap_left      <= 0;
         accepted_reqs <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            reassemble_segment(req_bus.data);
            accepted_reqs <= accepted_reqs + 1;
         end
         if (req_bus.valid && !req_bus.ready) begin
            // hold the offered request
         end else if (gap_left > 0) begin
            req_bus.valid <= 1'b0;
            gap_left      <= gap_left - 1;
         end else if (header_queue.size() != 0) begin
            req_bus.valid <= 1'b1;
            req_bus.data  <= header_queue.pop_front();
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   int rx_cycle;
   int hold_left;
   bit hold_done;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rx_cycle      <= 0;
         hold_left     <= 0;
         hold_done     <= 1'b0;
      end else begin
         rx_cycle <= rx_cycle + 1;
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left     <= hold_left - 1;
         end else if (!hold_done && accepted_reqs >= 40) begin
            rsp_bus.ready <= 1'b0;
            hold_left     <= 400;
            hold_done     <= 1'b1;
         end else begin
            case ((rx_cycle / 48) % 4)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom);
               2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= (rx_cycle % 3 != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = rsp_bus.data;
         if (predicted_results.size() == 0) begin
            $error("unexpected result status %0d entry %0d seq %0d", got.status, got.entry,
                   got.out_seq);
            failures++;
         end else begin
            want = predicted_results.pop_front();
            check_field("status", want.status, got.status);
            check_field("entry", want.entry, got.entry);
            check_field("out_seq", want.out_seq, got.out_seq);
            check_field("out_length", want.out_length, got.out_length);
            check_field("total_length", want.total_length, got.total_length);
            check_field("last", want.last, got.last);
         end
      end
   end

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      failures      = 0;
      req_bus.valid = 1'b0;
      req_bus.data  = '0;
      rsp_bus.ready = 1'b0;
      for (int e = 0; e < NUM_ENTRIES; e++) begin
         open_valid[e] = 1'b0;
         open_map[e]   = 16'd0;
      end
      build_stimulus();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      do @(negedge clock);
      while (header_queue.size() != 0 || req_bus.valid || predicted_results.size() != 0);
      repeat (40) @(negedge clock);
      if (predicted_results.size() != 0) begin
         $error("%0d expected results never arrived", predicted_results.size());
         failures++;
      end
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #(100000 * 12);
      $display("Verification failed");
      $finish;
   end

endmodule
